/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the interval table block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked, disabled during reset.
`define TIL_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("interval table assertion failed");

// Overlapping implication, clocked, disabled during reset.
`define TIL_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("interval table implication failed");

`endif

/* rtl/til_pkg.sv */
// Package for the timed interval table lookup: codes, defaults, FSM types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package til_pkg;

  // Default table depth and field widths
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int TIME_W          = 40;
  localparam int LIMIT_W         = 16;
  localparam int STATUS_W        = 3;
  localparam int IDX_OUT_W       = 10;
  localparam int CFG_IDX_W       = 2;

  // Register reset values
  localparam logic               SYNC_MODE_RST = 1'b1;
  localparam logic [LIMIT_W-1:0] HOLD_MS_RST   = 16'd2000;
  localparam logic [LIMIT_W-1:0] GAP_MS_RST    = 16'd3000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MS    = 2'd2;

  // Actions
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_EXACT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HOLD_LAST = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HOLD_GAP  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOSYNC    = 3'd6;

  // Flags carried by a search token along the cell chain
  typedef struct packed {
    logic done;
    logic hit;
  } til_flags_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_READ,
    CELL_CMP
  } cell_state_t;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_SEARCH,
    CTL_LAST_RD,
    CTL_LAST_CMP,
    CTL_SCAN_RD,
    CTL_SCAN_CMP
  } ctrl_state_t;

endpackage

/* rtl/til_cell.sv */
// One binary-search step cell: takes a search token from its left neighbor,
// reads the table at the midpoint, narrows the bounds and hands on. Uses til_pkg.
`timescale 1ns / 1ps

module til_cell import til_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  til_flags_t        in_flags,
  input  logic [CW-1:0]     in_lo,
  input  logic [CW-1:0]     in_hi1,
  input  logic [TIME_W-1:0] q,
  input  logic [TIME_W-1:0] rd_start,
  input  logic [TIME_W-1:0] rd_end,
  output logic              out_valid,
  output til_flags_t        out_flags,
  output logic [CW-1:0]     out_lo,
  output logic [CW-1:0]     out_hi1,
  output logic              rd_req,
  output logic [IW-1:0]     rd_addr
);

  cell_state_t   state;
  cell_state_t   state_next;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi1;
  logic [CW-1:0] mid;
  logic          in_live;
  logic          is_hit;
  logic          go_low;

  // Token still has a nonempty range to search
  assign in_live = in_valid && !in_flags.done && (in_lo < in_hi1);

  // Midpoint of [lo, hi1)
  assign mid = lo + ((hi1 - lo - CW'(1)) >> 1);

  // Compare the returned entry against the query
  assign is_hit = (q >= rd_start) && (q <= rd_end);
  assign go_low = q < rd_start;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CELL_IDLE: if (in_live) state_next = CELL_READ;
      CELL_READ: state_next = CELL_CMP;
      CELL_CMP:  state_next = CELL_IDLE;
      default:   state_next = CELL_IDLE;
    endcase
  end

  // Read request toward the shared table port
  always_comb begin
    rd_req  = (state == CELL_READ);
    rd_addr = mid[IW-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CELL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= ((state == CELL_IDLE) && in_valid && !in_live) || (state == CELL_CMP);
    end
  end

  // Token registers: capture, pass a finished token on, or narrow and hand on
  always_ff @(posedge clk) begin
    if (state == CELL_IDLE && in_valid) begin
      lo        <= in_lo;
      hi1       <= in_hi1;
      out_flags <= '{done: 1'b1, hit: in_flags.hit};
      out_lo    <= in_lo;
      out_hi1   <= in_hi1;
    end else if (state == CELL_CMP) begin
      if (is_hit) begin
        out_flags <= '{done: 1'b1, hit: 1'b1};
        out_lo    <= mid;
        out_hi1   <= hi1;
      end else if (go_low) begin
        out_flags <= '{done: 1'b0, hit: 1'b0};
        out_lo    <= lo;
        out_hi1   <= mid;
      end else begin
        out_flags <= '{done: 1'b0, hit: 1'b0};
        out_lo    <= mid + CW'(1);
        out_hi1   <= hi1;
      end
    end
  end

endmodule

/* rtl/timed_interval_table_lookup_top.sv */
// Top level of the timed interval table lookup: table memory, search cell chain,
// fallback sequencer and configuration registers. Uses til_pkg and til_cell.
//
// Usage: raise start with action and the time fields while busy is low; the
// beat is taken at that edge. Append (action 0) stores start_ms/end_ms at the
// next free slot; query (action 1) looks up query_ms. Every beat gives exactly
// one result on status/entry_index, marked by done for one cycle.
// Append, dropped beats and queries on an empty table answer in the cycle
// after acceptance. A query walks a chain of clog2(TABLE_DEPTH+1) cells
// (11 for 1024 entries): each cell that reads the table goes through its read
// and compare states, a cell after the search has ended passes the token on,
// and a hit is then reported. On a miss the sequencer reads the last entry and
// then scans backward one entry at a time for the gap fallback. Every step
// shares the single read port of the table memory.
// Throughput: one beat at a time; busy stays high until the result cycle.
// Reset: entry count cleared, sync_mode=1, hold 2000 ms, gap 3000 ms; table
// contents are not cleared. Results cannot be held off by the receiver.
// Configuration: cfg_we/cfg_idx/cfg_data write a register, idle only.
`timescale 1ns / 1ps

module timed_interval_table_lookup_top import til_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action,
  input  logic [TIME_W-1:0]    start_ms,
  input  logic [TIME_W-1:0]    end_ms,
  input  logic [TIME_W-1:0]    query_ms,
  output logic                 done,
  output logic [STATUS_W-1:0]  status,
  output logic [IDX_OUT_W-1:0] entry_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int NCELL = CW;

  // Configuration registers
  logic               sync_mode;
  logic [LIMIT_W-1:0] hold_ms;
  logic [LIMIT_W-1:0] gap_ms;

  // Table memory and its registered read port
  logic [TIME_W-1:0] start_mem [TABLE_DEPTH];
  logic [TIME_W-1:0] end_mem   [TABLE_DEPTH];
  logic [TIME_W-1:0] rd_start_q;
  logic [TIME_W-1:0] rd_end_q;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     chain_addr;
  logic [IW-1:0]     ctrl_addr;
  logic              mem_we;

  // Control and datapath registers
  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_m1;
  logic [IW-1:0]     last_idx;
  logic [TIME_W-1:0] q_reg;
  logic [IW-1:0]     scan_idx;
  logic [TIME_W-1:0] prev_start;

  // Result next values
  logic                res_valid_next;
  logic [STATUS_W-1:0] res_status_next;
  logic [IW-1:0]       res_idx_next;
  logic [31:0]         res_idx_wide;

  // Cell chain links
  logic          link_valid [NCELL+1];
  til_flags_t    link_flags [NCELL+1];
  logic [CW-1:0] link_lo    [NCELL+1];
  logic [CW-1:0] link_hi1   [NCELL+1];
  logic          cell_req   [NCELL];
  logic [IW-1:0] cell_addr  [NCELL];

  // Fallback compares
  logic              accept;
  logic              full;
  logic              end_below;
  logic [TIME_W-1:0] into;
  logic              hold_ok;
  logic [TIME_W:0]   gap;
  logic              gap_ok;

  assign busy     = (state != CTL_IDLE);
  assign accept   = start && !busy;
  assign full     = (count == CW'(TABLE_DEPTH));
  assign count_m1 = count - CW'(1);
  assign last_idx = count_m1[IW-1:0];

  assign end_below = rd_end_q < q_reg;
  assign into      = q_reg - rd_end_q;
  assign hold_ok   = into < {{(TIME_W-LIMIT_W){1'b0}}, hold_ms};
  assign gap       = {1'b0, prev_start} - {1'b0, rd_end_q};
  assign gap_ok    = ($signed(gap) < $signed({{(TIME_W+1-LIMIT_W){1'b0}}, gap_ms}))
                     && !gap[TIME_W] && (into < gap[TIME_W-1:0]);

  // Launch a search token into the first cell
  assign link_valid[0] = accept && sync_mode && (action == ACT_QUERY) && (count != '0);
  assign link_flags[0] = '{done: 1'b0, hit: 1'b0};
  assign link_lo[0]    = '0;
  assign link_hi1[0]   = count;

  // Search cell chain
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    til_cell #(.TABLE_DEPTH(TABLE_DEPTH)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_flags  (link_flags[k]),
      .in_lo     (link_lo[k]),
      .in_hi1    (link_hi1[k]),
      .q         (q_reg),
      .rd_start  (rd_start_q),
      .rd_end    (rd_end_q),
      .out_valid (link_valid[k+1]),
      .out_flags (link_flags[k+1]),
      .out_lo    (link_lo[k+1]),
      .out_hi1   (link_hi1[k+1]),
      .rd_req    (cell_req[k]),
      .rd_addr   (cell_addr[k])
    );
  end

  // Merge cell read requests; at most one cell reads at a time
  always_comb begin
    chain_addr = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (cell_req[k]) chain_addr = chain_addr | cell_addr[k];
    end
  end

  assign rd_addr = chain_addr | ctrl_addr;

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      start_mem[count[IW-1:0]] <= start_ms;
      end_mem[count[IW-1:0]]   <= end_ms;
    end
    rd_start_q <= start_mem[rd_addr];
    rd_end_q   <= end_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE:     if (link_valid[0]) state_next = CTL_SEARCH;
      CTL_SEARCH: begin
        if (link_valid[NCELL]) begin
          state_next = link_flags[NCELL].hit ? CTL_IDLE : CTL_LAST_RD;
        end
      end
      CTL_LAST_RD:  state_next = CTL_LAST_CMP;
      CTL_LAST_CMP: begin
        if (end_below || last_idx == '0) state_next = CTL_IDLE;
        else state_next = CTL_SCAN_RD;
      end
      CTL_SCAN_RD:  state_next = CTL_SCAN_CMP;
      CTL_SCAN_CMP: begin
        if (end_below || scan_idx == '0) state_next = CTL_IDLE;
        else state_next = CTL_SCAN_RD;
      end
      default:      state_next = CTL_IDLE;
    endcase
  end

  // Outputs: result, table write, fallback read address
  always_comb begin
    res_valid_next  = 1'b0;
    res_status_next = ST_NONE;
    res_idx_next    = '0;
    mem_we          = 1'b0;
    ctrl_addr       = '0;
    unique case (state)
      CTL_IDLE: begin
        if (accept) begin
          if (!sync_mode) begin
            res_valid_next  = 1'b1;
            res_status_next = ST_NOSYNC;
          end else if (action == ACT_APPEND) begin
            res_valid_next = 1'b1;
            if (full) begin
              res_status_next = ST_FULL;
            end else begin
              res_status_next = ST_APPENDED;
              res_idx_next    = count[IW-1:0];
              mem_we          = 1'b1;
            end
          end else if (count == '0) begin
            res_valid_next  = 1'b1;
            res_status_next = ST_NONE;
          end
        end
      end
      CTL_SEARCH: begin
        if (link_valid[NCELL] && link_flags[NCELL].hit) begin
          res_valid_next  = 1'b1;
          res_status_next = ST_EXACT;
          res_idx_next    = link_lo[NCELL][IW-1:0];
        end
      end
      CTL_LAST_RD: ctrl_addr = last_idx;
      CTL_LAST_CMP: begin
        if (end_below) begin
          res_valid_next = 1'b1;
          if (hold_ok) begin
            res_status_next = ST_HOLD_LAST;
            res_idx_next    = last_idx;
          end
        end else if (last_idx == '0) begin
          res_valid_next = 1'b1;
        end
      end
      CTL_SCAN_RD: ctrl_addr = scan_idx;
      CTL_SCAN_CMP: begin
        if (end_below) begin
          res_valid_next = 1'b1;
          if (gap_ok) begin
            res_status_next = ST_HOLD_GAP;
            res_idx_next    = scan_idx;
          end
        end else if (scan_idx == '0) begin
          res_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_idx_wide = 32'(res_idx_next);

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      count     <= '0;
      done      <= 1'b0;
      sync_mode <= SYNC_MODE_RST;
      hold_ms   <= HOLD_MS_RST;
      gap_ms    <= GAP_MS_RST;
    end else begin
      state <= state_next;
      done  <= res_valid_next;
      if (mem_we) count <= count + CW'(1);
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SYNC_MODE: sync_mode <= cfg_data[0];
          REG_HOLD_MS:   hold_ms   <= cfg_data;
          REG_GAP_MS:    gap_ms    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers: query, scan pointer, start of the entry above, result
  always_ff @(posedge clk) begin
    if (accept) q_reg <= query_ms;
    if (state == CTL_LAST_CMP) begin
      scan_idx   <= last_idx - IW'(1);
      prev_start <= rd_start_q;
    end else if (state == CTL_SCAN_CMP) begin
      scan_idx   <= scan_idx - IW'(1);
      prev_start <= rd_start_q;
    end
    if (res_valid_next) begin
      status      <= res_status_next;
      entry_index <= res_idx_wide[IDX_OUT_W-1:0];
    end
  end

endmodule

/* rtl/til_checker.sv */
// Port-level checker for the timed interval table lookup, bound to the top.
// Uses til_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module til_checker import til_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [STATUS_W-1:0]  status,
  input logic [IDX_OUT_W-1:0] entry_index
);

  logic no_entry;

  // Result beats that carry no entry
  assign no_entry = done && (status == ST_NONE || status == ST_FULL || status == ST_NOSYNC);

  // A result beat follows an accepted beat or the end of a busy stretch
  `TIL_IMPLIES(a_done_cause, clk, rst, done, $past(start && !busy) || $past(busy))

  // Busy ends only in the cycle that delivers the result
  `TIL_IMPLIES(a_busy_end_done, clk, rst, $fell(busy), done)

  // Busy starts only on an accepted beat
  `TIL_IMPLIES(a_busy_rise_start, clk, rst, $rose(busy), $past(start))

  // Answers without an entry report index zero
  `TIL_IMPLIES(a_idx_zero, clk, rst, no_entry, entry_index == '0)

  // Status stays within the defined codes
  `TIL_ASSERT(a_status_code, clk, rst, !done || status <= ST_NOSYNC)

endmodule

bind timed_interval_table_lookup_top til_checker u_til_checker (.*);

/* tb/tb_timed_interval_table_lookup_top.sv */
// Self-checking testbench for timed_interval_table_lookup_top: directed rows, then random
// phases of appends and queries scored by an in-bench interval table predictor.
// Depends on til_pkg and the block's top level only.
`timescale 1ns / 1ps

module tb_timed_interval_table_lookup_top;
  import til_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int DEPTH          = TABLE_DEPTH_DEF;
  localparam int TIMEOUT_CYCLES = 15_000_000;
  localparam logic [TIME_W-1:0] MAX_T = {TIME_W{1'b1}};

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [IDX_OUT_W-1:0] idx;
  } lookup_res_t;

  typedef enum bit {ROW_BEAT, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic                 act;
    logic [TIME_W-1:0]    s_ms;
    logic [TIME_W-1:0]    e_ms;
    logic [TIME_W-1:0]    q_ms;
    bit                   typed;
    lookup_res_t          res;
    logic                 sync;
    logic [LIMIT_W-1:0]   hold;
    logic [LIMIT_W-1:0]   gap;
  } dir_row_t;

  // DUT ports, inputs all known from time zero
  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 start    = 1'b0;
  logic                 action   = ACT_APPEND;
  logic [TIME_W-1:0]    start_ms = '0;
  logic [TIME_W-1:0]    end_ms   = '0;
  logic [TIME_W-1:0]    query_ms = '0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = REG_SYNC_MODE;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 busy;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [IDX_OUT_W-1:0] entry_index;

  // Predictor copy of the table and the registers
  logic [TIME_W-1:0]  ivl_start [DEPTH];
  logic [TIME_W-1:0]  ivl_end   [DEPTH];
  int                 ivl_count = 0;
  logic               sync_on   = SYNC_MODE_RST;
  logic [LIMIT_W-1:0] hold_lim  = HOLD_MS_RST;
  logic [LIMIT_W-1:0] gap_lim   = GAP_MS_RST;

  lookup_res_t pending_results[$];
  dir_row_t    dir_rows[$];
  lookup_res_t want;
  longint      cursor      = 0;
  int          burst_left  = 0;
  int          err_count   = 0;
  int          cycle_count = 0;
  int          n_appends   = 0;
  int          n_queries   = 0;
  int          n_drains    = 0;
  int          status_seen [8];

  timed_interval_table_lookup_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .start_ms   (start_ms),
    .end_ms     (end_ms),
    .query_ms   (query_ms),
    .done       (done),
    .status     (status),
    .entry_index(entry_index),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Apply one beat to the table copy and work out the result it owes
  function automatic lookup_res_t predict_lookup(input logic act,
                                                 input logic [TIME_W-1:0] s, e, q);
    lookup_res_t r;
    int          lo, hi, mid, i, last;
    longint      qv, ev, gapv, into;
    r.status = ST_NONE;
    r.idx    = '0;
    if (!sync_on) begin
      r.status = ST_NOSYNC;
      return r;
    end
    if (act == ACT_APPEND) begin
      if (ivl_count >= DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      ivl_start[ivl_count] = s;
      ivl_end[ivl_count]   = e;
      r.status = ST_APPENDED;
      r.idx    = IDX_OUT_W'(ivl_count);
      ivl_count++;
      return r;
    end
    if (ivl_count == 0) return r;
    // binary search, both ends inclusive
    lo = 0;
    hi = ivl_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (q >= ivl_start[mid] && q <= ivl_end[mid]) begin
        r.status = ST_EXACT;
        r.idx    = IDX_OUT_W'(mid);
        return r;
      end
      if (q < ivl_start[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    // past the last end: hold the last entry for a while
    qv   = longint'(q);
    last = ivl_count - 1;
    ev   = longint'(ivl_end[last]);
    if (ev < qv) begin
      if (qv - ev < longint'(hold_lim)) begin
        r.status = ST_HOLD_LAST;
        r.idx    = IDX_OUT_W'(last);
      end
      return r;
    end
    // narrow gap: keep the highest entry that ended before the query
    for (i = last; i >= 0; i--) begin
      ev = longint'(ivl_end[i]);
      if (ev < qv) begin
        if (i + 1 < ivl_count) begin
          gapv = longint'(ivl_start[i + 1]) - ev;
          into = qv - ev;
          if (gapv < longint'(gap_lim) && into < gapv) begin
            r.status = ST_HOLD_GAP;
            r.idx    = IDX_OUT_W'(i);
          end
        end
        break;
      end
    end
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand40();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Next interval of a time-ordered stream, with overlaps and inverted ones mixed in
  function automatic void next_interval(output logic [TIME_W-1:0] s, e);
    longint lead, len;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) lead = 0;
    else if (sel < 45) lead = $urandom_range(1, gap_lim + 1);
    else if (sel < 75) lead = longint'(gap_lim) + $urandom_range(0, 3000);
    else if (sel < 90) lead = $urandom_range(0, 20000);
    else lead = -longint'($urandom_range(1, 400));
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5000);
    s = TIME_W'(cursor + lead);
    if ($urandom_range(0, 19) == 0) begin
      e = s - TIME_W'(len + 1);
      cursor = cursor + lead;
    end else begin
      e = TIME_W'(cursor + lead + len);
      cursor = cursor + lead + len;
    end
  endfunction

  // Query time aimed at entries, their edges, gaps and the hold window
  function automatic logic [TIME_W-1:0] pick_query_time();
    int                sel, k, span;
    logic [TIME_W-1:0] s, e;
    sel = $urandom_range(0, 99);
    if (ivl_count == 0 || sel < 10) return rand40();
    if (sel < 30) begin
      e = ivl_end[ivl_count - 1];
      if ($urandom_range(0, 2) == 0) return e + hold_lim - 1 + $urandom_range(0, 2);
      return e + 1 + $urandom_range(0, hold_lim + 100);
    end
    if ($urandom_range(0, 9) < 6)
      k = ivl_count - 1 - $urandom_range(0, (ivl_count > 16) ? 15 : ivl_count - 1);
    else
      k = $urandom_range(0, ivl_count - 1);
    s = ivl_start[k];
    e = ivl_end[k];
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        span = (e >= s && e - s < 100000) ? int'(e - s) : 0;
        return s + $urandom_range(0, span);
      end
      3, 4, 5, 6: return e + 1 + $urandom_range(0, gap_lim + 200);
      7: return s - 1;
      8: return e;
      default: return e + 1;
    endcase
  endfunction

  function automatic void add_beat(input logic act, input logic [TIME_W-1:0] s, e, q,
                                   input bit typed, input logic [STATUS_W-1:0] st,
                                   input int ix);
    dir_row_t row;
    row.kind       = ROW_BEAT;
    row.act        = act;
    row.s_ms       = s;
    row.e_ms       = e;
    row.q_ms       = q;
    row.typed      = typed;
    row.res.status = st;
    row.res.idx    = IDX_OUT_W'(ix);
    row.sync       = 1'b0;
    row.hold       = '0;
    row.gap        = '0;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_cfg(input logic sync, input logic [LIMIT_W-1:0] hold, gap);
    dir_row_t row;
    row.kind  = ROW_CONFIG;
    row.act   = ACT_APPEND;
    row.s_ms  = '0;
    row.e_ms  = '0;
    row.q_ms  = '0;
    row.typed = 1'b0;
    row.res   = '0;
    row.sync  = sync;
    row.hold  = hold;
    row.gap   = gap;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Drop start and hold until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Bursts of back-to-back beats, random gaps, now and then a full drain
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 11) == 0) begin
        wait_drained();
        n_drains++;
      end else begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // Present one beat, hold it until taken, then record what it owes
  task automatic send_beat(input logic act, input logic [TIME_W-1:0] s, e, q,
                           input bit typed, input lookup_res_t typed_res);
    lookup_res_t r;
    start    <= 1'b1;
    action   <= act;
    start_ms <= s;
    end_ms   <= e;
    query_ms <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_lookup(act, s, e, q);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
    if (act == ACT_APPEND) n_appends++;
    else n_queries++;
    pace_sender();
  endtask

  // Write all three registers back to back while the block is idle
  task automatic apply_config(input logic sync, input logic [LIMIT_W-1:0] hold, gap);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_SYNC_MODE;
    cfg_data <= LIMIT_W'(sync);
    @(posedge clk);
    cfg_idx  <= REG_HOLD_MS;
    cfg_data <= hold;
    @(posedge clk);
    cfg_idx  <= REG_GAP_MS;
    cfg_data <= gap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sync_on  = sync;
    hold_lim = hold;
    gap_lim  = gap;
  endtask

  task automatic random_item(input int query_pct);
    logic [TIME_W-1:0] s, e;
    if (ivl_count > 0 && $urandom_range(0, 99) < query_pct) begin
      send_beat(ACT_QUERY, rand40(), rand40(), pick_query_time(), 1'b0, '0);
    end else begin
      next_interval(s, e);
      send_beat(ACT_APPEND, s, e, rand40(), 1'b0, '0);
    end
  endtask

  // Score every result beat against the oldest expectation; watch the clock
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && done) begin
      if (!$isunknown(status)) status_seen[status]++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected, status %0d index %0d",
                 $time, status, entry_index);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          err_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status);
        end
        if (entry_index !== want.idx) begin
          err_count++;
          $display("%0t: entry_index mismatch, expected %0d, actual %0d",
                   $time, want.idx, entry_index);
        end
      end
    end
  end

  initial begin
    int ph_items [7];
    int p;
    ph_items = '{100, 50, 90, 30, 100, 90, 60};
    foreach (status_seen[i]) status_seen[i] = 0;

    // Directed rows: empty table, a short ordered table, edges, limits, odd intervals
    add_beat(ACT_QUERY,  0, 0, 0,     1, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, MAX_T, 1, ST_NONE, 0);
    add_beat(ACT_APPEND, 1000,  2000,  0, 1, ST_APPENDED, 0);
    add_beat(ACT_APPEND, 3000,  5000,  0, 1, ST_APPENDED, 1);
    add_beat(ACT_APPEND, 10000, 12000, 0, 1, ST_APPENDED, 2);
    add_beat(ACT_QUERY,  0, 0, 1000,  1, ST_EXACT, 0);
    add_beat(ACT_QUERY,  0, 0, 2000,  1, ST_EXACT, 0);
    add_beat(ACT_QUERY,  0, 0, 2500,  0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 7000,  0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 500,   0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 13999, 0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 14000, 0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 12000, 1, ST_EXACT, 2);
    add_cfg(1'b1, '0, '0);
    add_beat(ACT_QUERY,  0, 0, 12001, 0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 2500,  0, ST_NONE, 0);
    add_cfg(1'b1, '1, '1);
    add_beat(ACT_QUERY,  0, 0, 12000 + 65534, 0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 7000,  0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, MAX_T, 0, ST_NONE, 0);
    add_beat(ACT_APPEND, 20000, 15000, 0, 1, ST_APPENDED, 3);
    add_beat(ACT_APPEND, 19000, 25000, 0, 1, ST_APPENDED, 4);
    add_beat(ACT_APPEND, 24000, 30000, 0, 1, ST_APPENDED, 5);
    add_beat(ACT_QUERY,  0, 0, 15500, 0, ST_NONE, 0);
    add_beat(ACT_QUERY,  0, 0, 27000, 0, ST_NONE, 0);
    add_cfg(1'b0, HOLD_MS_RST, GAP_MS_RST);
    add_beat(ACT_APPEND, 40000, 41000, 0, 1, ST_NOSYNC, 0);
    add_beat(ACT_QUERY,  0, 0, 1000,  1, ST_NOSYNC, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CONFIG)
        apply_config(dir_rows[r].sync, dir_rows[r].hold, dir_rows[r].gap);
      else
        send_beat(dir_rows[r].act, dir_rows[r].s_ms, dir_rows[r].e_ms, dir_rows[r].q_ms,
                  dir_rows[r].typed, dir_rows[r].res);
    end
    cursor = 30000;

    // Random phases over several register settings, limits among them
    for (p = 0; p < 7; p++) begin
      case (p)
        0: apply_config(1'b1, HOLD_MS_RST, GAP_MS_RST);
        1: apply_config(1'b1, '0, '0);
        2: apply_config(1'b1, '1, '1);
        3: apply_config(1'b0, LIMIT_W'($urandom), LIMIT_W'($urandom));
        5: apply_config(1'b1, 16'd200, 16'd10000);
        default: apply_config(1'b1, LIMIT_W'($urandom), LIMIT_W'($urandom));
      endcase
      repeat (ph_items[p]) random_item(55);
    end

    // Extreme and arbitrary intervals at the end of the table
    apply_config(1'b1, LIMIT_W'($urandom), LIMIT_W'($urandom));
    send_beat(ACT_APPEND, '0,    '0,    MAX_T, 1'b0, '0);
    send_beat(ACT_APPEND, MAX_T, MAX_T, '0,    1'b0, '0);
    send_beat(ACT_APPEND, '0,    MAX_T, '0,    1'b0, '0);
    send_beat(ACT_APPEND, MAX_T, '0,    MAX_T, 1'b0, '0);
    send_beat(ACT_QUERY, MAX_T, MAX_T, '0,    1'b0, '0);
    send_beat(ACT_QUERY, '0,    '0,    MAX_T, 1'b0, '0);
    repeat (40) random_item(70);
    apply_config(1'b0, HOLD_MS_RST, GAP_MS_RST);
    send_beat(ACT_APPEND, rand40(), rand40(), rand40(), 1'b0, '0);
    send_beat(ACT_QUERY,  rand40(), rand40(), rand40(), 1'b0, '0);

    // Let the last result drain, then a short quiet tail
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Run: %0d beats (%0d appends, %0d queries), table at %0d of %0d, %0d drains",
             n_appends + n_queries, n_appends, n_queries, ivl_count, DEPTH, n_drains);
    $display("Mix: %0d exact %0d last %0d gap %0d none %0d app %0d full %0d nosync",
             status_seen[ST_EXACT], status_seen[ST_HOLD_LAST], status_seen[ST_HOLD_GAP],
             status_seen[ST_NONE], status_seen[ST_APPENDED], status_seen[ST_FULL],
             status_seen[ST_NOSYNC]);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/til_pkg.sv
rtl/til_cell.sv
rtl/timed_interval_table_lookup_top.sv
rtl/til_checker.sv
tb/tb_timed_interval_table_lookup_top.sv
